// ===== rtl/bmo_pkg.sv =====
// Package for the bicycle model odometry block.
// Holds fixed-point constants, register indexes, the arctangent table and
// a saturation helper. It depends on nothing else.
`default_nettype none

package bmo_pkg;

	localparam int CORDIC_ITER_DEF = 24;
	localparam int TAB_IW          = 5;

	localparam logic signed [35:0] PI_Q28      = 36'sd843314857;
	localparam logic signed [35:0] TWO_PI_Q28  = 36'sd1686629714;
	localparam logic signed [35:0] HALF_PI_Q28 = 36'sd421657428;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

	localparam logic [24:0] STEER_LIMIT = 25'd26214400;
	localparam logic [16:0] RATIO_LIMIT = 17'd65536;
	localparam logic [24:0] STEP_LIMIT  = 25'd16777216;

	localparam logic [2:0] REG_SPEED_SCALE     = 3'd0;
	localparam logic [2:0] REG_STEERING_CENTER = 3'd1;
	localparam logic [2:0] REG_STEERING_SCALE  = 3'd2;
	localparam logic [2:0] REG_MAX_STEER       = 3'd3;
	localparam logic [2:0] REG_REAR_RATIO      = 3'd4;
	localparam logic [2:0] REG_INV_REAR_LENGTH = 3'd5;
	localparam logic [2:0] REG_TIME_STEP       = 3'd6;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [33:0] angle;
		logic               neg;
	} fold_t;

	// Arctangent of 2^-i in Q.28 radians.
	function automatic logic [27:0] atan_q28(input logic [TAB_IW-1:0] idx);
		logic [27:0] r;
		case (idx)
			5'd0: r = 28'd210828714;
			5'd1: r = 28'd124459457;
			5'd2: r = 28'd65760959;
			5'd3: r = 28'd33381290;
			5'd4: r = 28'd16755422;
			5'd5: r = 28'd8385879;
			5'd6: r = 28'd4193963;
			5'd7: r = 28'd2097109;
			5'd8: r = 28'd1048571;
			5'd9: r = 28'd524287;
			5'd10: r = 28'd262144;
			5'd11: r = 28'd131072;
			5'd12: r = 28'd65536;
			5'd13: r = 28'd32768;
			5'd14: r = 28'd16384;
			5'd15: r = 28'd8192;
			5'd16: r = 28'd4096;
			5'd17: r = 28'd2048;
			5'd18: r = 28'd1024;
			5'd19: r = 28'd512;
			5'd20: r = 28'd256;
			5'd21: r = 28'd128;
			5'd22: r = 28'd64;
			5'd23: r = 28'd32;
			5'd24: r = 28'd16;
			5'd25: r = 28'd8;
			5'd26: r = 28'd4;
			5'd27: r = 28'd2;
			5'd28: r = 28'd1;
			default: r = 28'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(SAT_MAX)) begin
			r = SAT_MAX;
		end else if (v < 64'(SAT_MIN)) begin
			r = SAT_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/bicycle_model_odometry.sv =====
// Top level of the bicycle model odometry block: APB registers, one shared
// multiplier, one shared CORDIC stage and the sequencer that drives them.
// Depends on bmo_pkg.
//
//  channel | signals                           | direction | word
//  --------+-----------------------------------+-----------+---------------------------
//  tick    | tick_valid, tick_ready            | in        | speed_raw, steering_raw
//  pose    | pose_valid, pose_ready            | out       | pos_x, pos_y, heading
//  apb     | psel, penable, pwrite, paddr, ... | in/out    | pwdata, prdata (32 bits)
//
// A tick word runs through four CORDIC passes on the one shared stage between
// its acceptance and the pose load, and the next tick is taken once the
// sequencer is back in idle. The heading wrap adds or subtracts a full turn
// until the sum lies in range, so it runs longer the further out the sum is.
// Reset clears the pose to zero and loads the register defaults; no clear
// pass is needed. A finished pose sits in its own output register, so the
// block goes back to idle and takes the next tick while it waits; only the
// final load waits if the previous pose is still untaken.
`default_nettype none

module bicycle_model_odometry #(
	parameter int CORDIC_ITERATIONS = bmo_pkg::CORDIC_ITER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               tick_valid,
	output logic                    tick_ready,
	input  wire logic signed [15:0] speed_raw,
	input  wire logic signed [15:0] steering_raw,
	output logic                    pose_valid,
	input  wire logic               pose_ready,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [30:0]      heading
);
	import bmo_pkg::*;

	localparam int CW = $clog2(CORDIC_ITERATIONS);
	localparam logic [CW-1:0] LAST_ITER = CW'(CORDIC_ITERATIONS - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_M_SPD, S_M_DLO, S_M_DHI, S_DIST, S_STEER, S_CORDIC,
		S_M_RATIO, S_VEC, S_ROT_B, S_ROT_H, S_M_TURN, S_TURN, S_M_DH,
		S_M_X, S_M_Y, S_Y, S_WRAP, S_DONE
	} state_t;

	typedef enum logic [1:0] {P_STEER, P_BETA, P_SB, P_HEAD} pass_t;

	state_t state_q;
	pass_t  pass_q;

	// Configuration registers.
	logic signed [31:0] speed_scale_q;
	logic signed [15:0] steering_center_q;
	logic signed [31:0] steering_scale_q;
	logic [24:0]        max_steer_q;
	logic [16:0]        rear_ratio_q;
	logic [23:0]        inv_rear_length_q;
	logic [24:0]        time_step_q;

	// Pose state.
	logic signed [31:0] x_q, y_q, yaw_q;

	// Working registers.
	logic signed [15:0] speed_raw_q, steering_raw_q;
	logic signed [65:0] prod_q;
	logic [15:0]        p1_q;
	logic [48:0]        acc_q;
	logic signed [31:0] dist_q, turn_q, beta_q;
	logic signed [32:0] cs_q, ss_q, sb_q;
	logic signed [35:0] h_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic               neg_q, vec_q;
	logic [CW-1:0]      cnt_q;

	logic signed [31:0] pos_x_q, pos_y_q;
	logic signed [30:0] heading_q;
	logic               pose_valid_q;
	logic               pose_load;

	// Clamped register values.
	logic [24:0] lim_eff, dt_eff;
	logic [16:0] ratio_eff;

	assign lim_eff   = (max_steer_q > STEER_LIMIT) ? STEER_LIMIT : max_steer_q;
	assign dt_eff    = (time_step_q > STEP_LIMIT) ? STEP_LIMIT : time_step_q;
	assign ratio_eff = (rear_ratio_q > RATIO_LIMIT) ? RATIO_LIMIT : rear_ratio_q;

	// Fold an angle beyond a quarter turn back by half a turn; the rotated
	// vector is then negated at the end of the pass.
	function automatic fold_t fold(input logic signed [33:0] a);
		fold_t r;
		r.angle = a;
		r.neg   = 1'b0;
		if (a > 34'(HALF_PI_Q28)) begin
			r.angle = a - 34'(PI_Q28);
			r.neg   = 1'b1;
		end else if (a < -34'(HALF_PI_Q28)) begin
			r.angle = a + 34'(PI_Q28);
			r.neg   = 1'b1;
		end
		return r;
	endfunction

	// Shared multiplier operand selection. The speed in Q.16 is the speed
	// product without its low eight bits; it is multiplied by the time step
	// in a low and a high half.
	logic signed [32:0] mul_a, mul_b;
	logic signed [16:0] steer_diff;

	assign steer_diff = 17'(steering_raw_q) - 17'(steering_center_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_M_SPD: begin
				mul_a = 33'(speed_scale_q);
				mul_b = 33'(speed_raw_q);
			end
			S_M_DLO: begin
				mul_a = $signed({9'b0, prod_q[31:8]});
				mul_b = $signed({8'b0, dt_eff});
			end
			S_M_DHI: begin
				mul_a = 33'($signed(p1_q));
				mul_b = $signed({8'b0, dt_eff});
			end
			S_DIST: begin
				mul_a = 33'(steer_diff);
				mul_b = 33'(steering_scale_q);
			end
			S_M_RATIO: begin
				mul_a = ss_q;
				mul_b = $signed({16'b0, ratio_eff});
			end
			S_M_TURN: begin
				mul_a = 33'(dist_q);
				mul_b = $signed({9'b0, inv_rear_length_q});
			end
			S_M_DH: begin
				mul_a = 33'(turn_q);
				mul_b = sb_q;
			end
			S_M_X: begin
				mul_a = 33'(dist_q);
				mul_b = cs_q;
			end
			S_M_Y: begin
				mul_a = 33'(dist_q);
				mul_b = ss_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared CORDIC stage: one micro-rotation per cycle.
	logic signed [33:0] xs, ys, tab, nx, ny, nz, fx, fy;
	logic               dir;

	assign xs  = cx_q >>> cnt_q;
	assign ys  = cy_q >>> cnt_q;
	assign tab = $signed({6'b0, atan_q28(TAB_IW'(cnt_q))});
	assign dir = vec_q ? cy_q[33] : !cz_q[33];

	always_comb begin
		if (dir) begin
			nx = cx_q - ys;
			ny = cy_q + xs;
			nz = cz_q - tab;
		end else begin
			nx = cx_q + ys;
			ny = cy_q - xs;
			nz = cz_q + tab;
		end
		fx = neg_q ? -nx : nx;
		fy = neg_q ? -ny : ny;
	end

	// Distance sum of the two partial products, and the clamped steer angle.
	logic signed [73:0] wide;
	logic signed [48:0] st_p, lim49;
	logic signed [25:0] steer;
	logic signed [33:0] steer_ang;
	fold_t              fold_s, fold_b, fold_h;

	assign wide  = $signed({prod_q[48], prod_q[48:0], 24'b0}) + $signed({25'b0, acc_q});
	assign st_p  = prod_q[48:0];
	assign lim49 = $signed({24'b0, lim_eff});

	always_comb begin
		if (st_p > lim49) begin
			steer = 26'(lim49);
		end else if (st_p < -lim49) begin
			steer = 26'(-lim49);
		end else begin
			steer = 26'(st_p);
		end
	end

	assign steer_ang = $signed({{4{steer[25]}}, steer, 4'b0});
	assign fold_s    = fold(steer_ang);
	assign fold_b    = fold(34'(beta_q));
	assign fold_h    = fold(34'(yaw_q) + 34'(beta_q));

	assign tick_ready = (state_q == S_IDLE);
	assign pready     = 1'b1;
	assign pose_valid = pose_valid_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign heading    = heading_q;

	// The finished pose moves to the output register once that is free.
	assign pose_load = (state_q == S_DONE) && (!pose_valid_q || pose_ready);

	// Register readback.
	always_comb begin
		case (paddr[4:2])
			REG_SPEED_SCALE:     prdata = speed_scale_q;
			REG_STEERING_CENTER: prdata = 32'(steering_center_q);
			REG_STEERING_SCALE:  prdata = steering_scale_q;
			REG_MAX_STEER:       prdata = {7'b0, max_steer_q};
			REG_REAR_RATIO:      prdata = {15'b0, rear_ratio_q};
			REG_INV_REAR_LENGTH: prdata = {8'b0, inv_rear_length_q};
			REG_TIME_STEP:       prdata = {7'b0, time_step_q};
			default:             prdata = '0;
		endcase
	end

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q     <= -32'sd9440;
			steering_center_q <= 16'sd100;
			steering_scale_q  <= -32'sd95167;
			max_steer_q       <= 25'd25165824;
			rear_ratio_q      <= 17'd32768;
			inv_rear_length_q <= 24'd504123;
			time_step_q       <= 25'd559241;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_SPEED_SCALE:     speed_scale_q     <= pwdata;
				REG_STEERING_CENTER: steering_center_q <= pwdata[15:0];
				REG_STEERING_SCALE:  steering_scale_q  <= pwdata;
				REG_MAX_STEER:       max_steer_q       <= pwdata[24:0];
				REG_REAR_RATIO:      rear_ratio_q      <= pwdata[16:0];
				REG_INV_REAR_LENGTH: inv_rear_length_q <= pwdata[23:0];
				REG_TIME_STEP:       time_step_q       <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	// Multiplier output register.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequencer with its datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pass_q       <= P_STEER;
			pose_valid_q <= 1'b0;
			x_q          <= '0;
			y_q          <= '0;
			yaw_q        <= '0;
			cnt_q        <= '0;
		end else begin
			if (pose_valid_q && pose_ready && !pose_load) begin
				pose_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (tick_valid) begin
						speed_raw_q    <= speed_raw;
						steering_raw_q <= steering_raw;
						state_q        <= S_M_SPD;
					end
				end
				S_M_SPD: state_q <= S_M_DLO;
				S_M_DLO: begin
					p1_q    <= prod_q[47:32];
					state_q <= S_M_DHI;
				end
				S_M_DHI: begin
					acc_q   <= prod_q[48:0];
					state_q <= S_DIST;
				end
				S_DIST: begin
					dist_q  <= sat32(64'($signed(wide[73:24])));
					state_q <= S_STEER;
				end
				S_STEER: begin
					cx_q    <= GAIN_Q30;
					cy_q    <= '0;
					cz_q    <= fold_s.angle;
					neg_q   <= fold_s.neg;
					vec_q   <= 1'b0;
					cnt_q   <= '0;
					pass_q  <= P_STEER;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					cx_q  <= nx;
					cy_q  <= ny;
					cz_q  <= nz;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ITER) begin
						case (pass_q)
							P_STEER: begin
								cs_q    <= fx[32:0];
								ss_q    <= fy[32:0];
								state_q <= S_M_RATIO;
							end
							P_BETA: begin
								beta_q  <= nz[31:0];
								state_q <= S_ROT_B;
							end
							P_SB: begin
								sb_q    <= fy[32:0];
								state_q <= S_ROT_H;
							end
							P_HEAD: begin
								cs_q    <= fx[32:0];
								ss_q    <= fy[32:0];
								state_q <= S_M_TURN;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_M_RATIO: state_q <= S_VEC;
				S_VEC: begin
					cx_q    <= 34'(cs_q);
					cy_q    <= $signed(prod_q[49:16]);
					cz_q    <= '0;
					neg_q   <= 1'b0;
					vec_q   <= 1'b1;
					cnt_q   <= '0;
					pass_q  <= P_BETA;
					state_q <= S_CORDIC;
				end
				S_ROT_B: begin
					cx_q    <= GAIN_Q30;
					cy_q    <= '0;
					cz_q    <= fold_b.angle;
					neg_q   <= fold_b.neg;
					vec_q   <= 1'b0;
					cnt_q   <= '0;
					pass_q  <= P_SB;
					state_q <= S_CORDIC;
				end
				S_ROT_H: begin
					cx_q    <= GAIN_Q30;
					cy_q    <= '0;
					cz_q    <= fold_h.angle;
					neg_q   <= fold_h.neg;
					vec_q   <= 1'b0;
					cnt_q   <= '0;
					pass_q  <= P_HEAD;
					state_q <= S_CORDIC;
				end
				S_M_TURN: state_q <= S_TURN;
				S_TURN: begin
					turn_q  <= sat32(64'($signed(prod_q[55:4])));
					state_q <= S_M_DH;
				end
				S_M_DH: state_q <= S_M_X;
				S_M_X: begin
					h_q     <= 36'(yaw_q) + 36'($signed(prod_q[64:30])) + PI_Q28;
					state_q <= S_M_Y;
				end
				S_M_Y: begin
					x_q     <= sat32(64'(x_q) + 64'($signed(prod_q[65:30])));
					state_q <= S_Y;
				end
				S_Y: begin
					y_q     <= sat32(64'(y_q) + 64'($signed(prod_q[65:30])));
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (h_q < 0) begin
						h_q <= h_q + TWO_PI_Q28;
					end else if (h_q >= TWO_PI_Q28) begin
						h_q <= h_q - TWO_PI_Q28;
					end else begin
						yaw_q   <= 32'(h_q - PI_Q28);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (pose_load) begin
						pos_x_q      <= x_q;
						pos_y_q      <= y_q;
						heading_q    <= yaw_q[30:0];
						pose_valid_q <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The wrapped heading always lies within one half turn of zero.
	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_q >= -32'(PI_Q28)) && (yaw_q < 32'(PI_Q28)))
		else $error("heading state out of range");

	// The iteration counter never passes the last micro-rotation.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORDIC) |-> (cnt_q <= LAST_ITER))
		else $error("CORDIC counter overrun");

	// The wrap loop only sees values less than two turns outside the target range.
	a_wrap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRAP) |-> ((h_q > -(TWO_PI_Q28 + TWO_PI_Q28))
		&& (h_q < (TWO_PI_Q28 + TWO_PI_Q28 + TWO_PI_Q28))))
		else $error("heading sum beyond wrap bound");

	// A pose that has not been taken is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && pose_valid_q && !pose_ready) |=> (state_q == S_DONE))
		else $error("pending pose overwritten");

	// An accepted tick leaves idle at once.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_valid && tick_ready) |=> !tick_ready)
		else $error("tick accepted without leaving idle");

endmodule

`default_nettype wire
